// ===== rtl/core/scnp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scnp_pkg: shared types and constants of the sphere/capsule narrow phase.
// Holds the transfer payload structs, the fixed-point formats and the
// widths of the internal datapath.
// ----------------------------------------------------------------------------
package scnp_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int DIR_FRAC_BITS = 14;

   // Distance cut-off for the direction, one LSB rounding of 1e-4.
   localparam int EPS_LSB = ((1 << FRAC_BITS) + 5000) / 10000;
   // Squared cut-off at the doubled length scale.
   localparam int EPS_SQ  = (2 * EPS_LSB) * (2 * EPS_LSB);

   localparam int POS_W  = 32;
   localparam int RAD_W  = 31;
   localparam int DIR_W  = 16;
   localparam int PUSH_W = 32;

   localparam int VEC_W  = POS_W + 2;          // doubled-scale offset magnitude
   localparam int HALF_W = (VEC_W + 1) / 2;    // square split into halves
   localparam int PP_W   = 2 * HALF_W;
   localparam int SQ_W   = 2 * VEC_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int M_W    = RAD_W + 2;          // doubled radius sum
   localparam int ROOT_W = M_W;                // root of a hit stays below M
   localparam int RADIC_W = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int QW     = DIR_FRAC_BITS + 1;  // quotient bits below saturation
   localparam int NUM_W  = VEC_W + DIR_FRAC_BITS + 1;

   typedef struct packed {
      logic                     kind_a;
      logic signed [POS_W-1:0]  pos_a_x;
      logic signed [POS_W-1:0]  pos_a_y;
      logic signed [POS_W-1:0]  pos_a_z;
      logic        [RAD_W-1:0]  radius_a;
      logic        [RAD_W-1:0]  height_a;
      logic                     kind_b;
      logic signed [POS_W-1:0]  pos_b_x;
      logic signed [POS_W-1:0]  pos_b_y;
      logic signed [POS_W-1:0]  pos_b_z;
      logic        [RAD_W-1:0]  radius_b;
      logic        [RAD_W-1:0]  height_b;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DIR_W-1:0]  dir_x;
      logic signed [DIR_W-1:0]  dir_y;
      logic signed [DIR_W-1:0]  dir_z;
      logic        [PUSH_W-1:0] push_len;
   } rsp_type;

endpackage

// ===== rtl/core/sphere_capsule_narrow_phase.sv =====
// Throughput: one pair per cycle unless a held response freezes the
// pipeline; the 33-step root and 15-step divider are fully pipelined,
// one stage per root bit and per quotient bit.
// Reset: synchronous, active high; clears every stage valid bit, so the
// pipeline comes out of reset empty and ready.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_capsule_narrow_phase
// Pipelined overlap test of two spheres or vertical capsules: reports hit,
// a unit push direction from A toward B and the penetration depth.
// ----------------------------------------------------------------------------
module sphere_capsule_narrow_phase (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  scnp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output scnp_pkg::rsp_type rsp_data
);

   localparam int VW   = scnp_pkg::VEC_W;
   localparam int HW   = scnp_pkg::HALF_W;
   localparam int PW   = scnp_pkg::PP_W;
   localparam int SW   = scnp_pkg::SQ_W;
   localparam int UW   = scnp_pkg::SUM_W;
   localparam int MW   = scnp_pkg::M_W;
   localparam int RW   = scnp_pkg::ROOT_W;
   localparam int CW   = scnp_pkg::RADIC_W;
   localparam int EW   = scnp_pkg::REM_W;
   localparam int QW   = scnp_pkg::QW;
   localparam int NW   = scnp_pkg::NUM_W;
   localparam int DW   = scnp_pkg::DIR_W;
   localparam int PUW  = scnp_pkg::PUSH_W;
   localparam int DFB  = scnp_pkg::DIR_FRAC_BITS;
   // Six front stages, the root, a post stage, a saturation stage, the
   // divider and the response register.
   localparam int DEPTH = 6 + RW + 2 + QW + 1;

   // Carry-along data of the root stages.
   typedef struct packed {
      logic          hit;
      logic          big;
      logic [2:0]    neg;
      logic [VW-1:0] ax;
      logic [VW-1:0] ay;
      logic [VW-1:0] az;
      logic [MW-1:0] m;
   } sq_cr_type;

   // Carry-along data of the divider stages.
   typedef struct packed {
      logic           hit;
      logic           big;
      logic [2:0]     neg;
      logic [2:0]     sat;
      logic [PUW-1:0] push;
      logic [RW-1:0]  r;
   } dv_cr_type;

   // The whole pipeline advances together; a held response freezes it.
   logic             adv;
   logic [DEPTH-1:0] vld_ff;

   assign adv       = !vld_ff[DEPTH-1] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: offsets at doubled scale and the y intervals of both
   // segments. A sphere has a zero-length segment.
   // ------------------------------------------------------------------
   logic [VW-1:0]   vx_ff, vz_ff, lo_a_ff, hi_a_ff, lo_b_ff, hi_b_ff;
   logic [MW-1:0]   m1_ff;
   logic [VW-1:0]   ha_in, hb_in, ya2_in, yb2_in;
   logic [VW-2:0]   dx_in, dz_in;

   always_comb begin
      ha_in  = req_data.kind_a ? VW'(req_data.height_a) : '0;
      hb_in  = req_data.kind_b ? VW'(req_data.height_b) : '0;
      ya2_in = {req_data.pos_a_y[31], req_data.pos_a_y, 1'b0};
      yb2_in = {req_data.pos_b_y[31], req_data.pos_b_y, 1'b0};
      dx_in  = {req_data.pos_b_x[31], req_data.pos_b_x}
             - {req_data.pos_a_x[31], req_data.pos_a_x};
      dz_in  = {req_data.pos_b_z[31], req_data.pos_b_z}
             - {req_data.pos_a_z[31], req_data.pos_a_z};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff   <= {dx_in, 1'b0};
         vz_ff   <= {dz_in, 1'b0};
         lo_a_ff <= ya2_in - ha_in;
         hi_a_ff <= ya2_in + ha_in;
         lo_b_ff <= yb2_in - hb_in;
         hi_b_ff <= yb2_in + hb_in;
         m1_ff   <= {(MW-1)'(req_data.radius_a) + (MW-1)'(req_data.radius_b), 1'b0};
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: gap between the y intervals, then magnitudes and signs.
   // Overlapping intervals give a zero y component.
   // ------------------------------------------------------------------
   logic [VW-1:0] ax_ff, ay_ff, az_ff;
   logic [2:0]    neg2_ff;
   logic [MW-1:0] m2_ff;
   logic          above_in, below_in;
   logic [VW:0]   dpos_in, dneg_in;

   always_comb begin
      above_in = $signed(lo_b_ff) > $signed(hi_a_ff);
      below_in = $signed(hi_b_ff) < $signed(lo_a_ff);
      dpos_in  = {lo_b_ff[VW-1], lo_b_ff} - {hi_a_ff[VW-1], hi_a_ff};
      dneg_in  = {lo_a_ff[VW-1], lo_a_ff} - {hi_b_ff[VW-1], hi_b_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff   <= vx_ff[VW-1] ? (~vx_ff + VW'(1)) : vx_ff;
         az_ff   <= vz_ff[VW-1] ? (~vz_ff + VW'(1)) : vz_ff;
         ay_ff   <= above_in ? dpos_in[VW-1:0] : (below_in ? dneg_in[VW-1:0] : '0);
         neg2_ff <= {vz_ff[VW-1], !above_in && below_in, vx_ff[VW-1]};
         m2_ff   <= m1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: half-width partial products of the four squares
   // (x, y, z and the radius sum).
   // ------------------------------------------------------------------
   logic [VW-1:0] sqin [4];
   logic [PW-1:0] p00_ff [4];
   logic [PW-1:0] p01_ff [4];
   logic [PW-1:0] p11_ff [4];
   sq_cr_type     cr3_ff, cr4_ff, cr5_ff;

   assign sqin[0] = ax_ff;
   assign sqin[1] = ay_ff;
   assign sqin[2] = az_ff;
   assign sqin[3] = VW'(m2_ff);

   for (genvar g = 0; g < 4; g++) begin : g_pp
      logic [HW-1:0] lo_h, hi_h;
      assign lo_h = HW'(sqin[g]);
      assign hi_h = HW'(sqin[g] >> HW);
      always_ff @(posedge clock) begin
         if (adv) begin
            p00_ff[g] <= PW'(lo_h) * PW'(lo_h);
            p01_ff[g] <= PW'(lo_h) * PW'(hi_h);
            p11_ff[g] <= PW'(hi_h) * PW'(hi_h);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cr3_ff <= '{hit: 1'b0, big: 1'b0, neg: neg2_ff, ax: ax_ff, ay: ay_ff,
                     az: az_ff, m: m2_ff};
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: assemble the exact squares.
   // ------------------------------------------------------------------
   logic [SW-1:0] sq_ff [4];

   for (genvar g = 0; g < 4; g++) begin : g_sq
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[g] <= (SW'(p11_ff[g]) << (2 * HW)) + (SW'(p01_ff[g]) << (HW + 1))
                      + SW'(p00_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cr4_ff <= cr3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: squared distance S.  Stage 6: hit and cut-off compares.
   // ------------------------------------------------------------------
   logic [UW-1:0] s_ff;
   logic [SW-1:0] msq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff   <= UW'(sq_ff[0]) + UW'(sq_ff[1]) + UW'(sq_ff[2]);
         msq_ff <= sq_ff[3];
         cr5_ff <= cr4_ff;
      end
   end

   // Root pipeline arrays: index 0 is loaded by stage 6, index k by root
   // step k-1. A hit has S below M*M, so the radicand fits RADIC_W bits.
   logic [CW-1:0] rt_rad_ff  [RW+1];
   logic [EW-1:0] rt_rem_ff  [RW+1];
   logic [RW-1:0] rt_root_ff [RW+1];
   sq_cr_type     rt_cr_ff   [RW+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_rad_ff[0]  <= CW'(s_ff);
         rt_rem_ff[0]  <= '0;
         rt_root_ff[0] <= '0;
         rt_cr_ff[0]   <= '{hit: s_ff < UW'(msq_ff),
                            big: s_ff > UW'(scnp_pkg::EPS_SQ),
                            neg: cr5_ff.neg, ax: cr5_ff.ax, ay: cr5_ff.ay,
                            az: cr5_ff.az, m: cr5_ff.m};
      end
   end

   // ------------------------------------------------------------------
   // Root steps: one result bit per stage, digit by digit, floor(sqrt(S)).
   // ------------------------------------------------------------------
   for (genvar k = 0; k < RW; k++) begin : g_root
      logic [EW+1:0] rnew, trial;
      logic          ge;
      assign rnew  = {rt_rem_ff[k], rt_rad_ff[k][CW-1 -: 2]};
      assign trial = (EW+2)'({rt_root_ff[k], 2'b01});
      assign ge    = rnew >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            rt_rad_ff[k+1]  <= rt_rad_ff[k] << 2;
            rt_rem_ff[k+1]  <= ge ? EW'(rnew - trial) : EW'(rnew);
            rt_root_ff[k+1] <= {rt_root_ff[k][RW-2:0], ge};
            rt_cr_ff[k+1]   <= rt_cr_ff[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Post stage: push depth and rounded division numerators.
   // ------------------------------------------------------------------
   sq_cr_type     rcr;
   logic [RW-1:0] rr;
   logic [NW-1:0] num_ff [3];
   logic [VW-1:0] mag    [3];
   dv_cr_type     pcr_ff;
   logic [RW:0]   pdiff;

   assign rcr    = rt_cr_ff[RW];
   assign rr     = rt_root_ff[RW];
   assign mag[0] = rcr.ax;
   assign mag[1] = rcr.ay;
   assign mag[2] = rcr.az;
   assign pdiff  = {1'b0, rcr.m} - {1'b0, rr} + (RW+1)'(1);

   for (genvar c = 0; c < 3; c++) begin : g_num
      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[c] <= NW'({mag[c], {DFB{1'b0}}}) + NW'(rr >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pcr_ff <= '{hit: rcr.hit, big: rcr.big, neg: rcr.neg, sat: 3'b000,
                     push: PUW'(pdiff >> 1), r: rr};
      end
   end

   // Divider arrays: index 0 is loaded by the saturation stage.
   logic [NW-1:0] dv_rem_ff [QW+1][3];
   logic [QW-1:0] dv_q_ff   [QW+1][3];
   dv_cr_type     dv_cr_ff  [QW+1];
   logic [2:0]    sat_in;

   for (genvar c = 0; c < 3; c++) begin : g_sat
      assign sat_in[c] = num_ff[c] >= NW'({pcr_ff.r, {QW{1'b0}}});
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[0][c] <= num_ff[c];
            dv_q_ff[0][c]   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_cr_ff[0] <= '{hit: pcr_ff.hit, big: pcr_ff.big, neg: pcr_ff.neg,
                          sat: sat_in, push: pcr_ff.push, r: pcr_ff.r};
      end
   end

   // ------------------------------------------------------------------
   // Divider steps: restoring division, one quotient bit per stage.
   // ------------------------------------------------------------------
   for (genvar i = 0; i < QW; i++) begin : g_div
      for (genvar c = 0; c < 3; c++) begin : g_cmp
         logic [NW-1:0] dsh;
         logic          ge;
         assign dsh = NW'(dv_cr_ff[i].r) << (QW - 1 - i);
         assign ge  = dv_rem_ff[i][c] >= dsh;
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[i+1][c] <= ge ? dv_rem_ff[i][c] - dsh : dv_rem_ff[i][c];
               dv_q_ff[i+1][c]   <= {dv_q_ff[i][c][QW-2:0], ge};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_cr_ff[i+1] <= dv_cr_ff[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Response stage: saturate, apply signs, and select the special cases.
   // No hit gives all zero fields; a near-zero distance gives (0, 0, 1).
   // ------------------------------------------------------------------
   localparam logic [DW-1:0] LIM = DW'(1) << DFB;

   dv_cr_type         fcr;
   logic [DW-1:0]     dres [3];
   scnp_pkg::rsp_type rsp_in;
   scnp_pkg::rsp_type rsp_ff;

   assign fcr = dv_cr_ff[QW];

   for (genvar c = 0; c < 3; c++) begin : g_dir
      logic [DW-1:0] mg;
      assign mg      = (fcr.sat[c] || (DW'(dv_q_ff[QW][c]) > LIM)) ? LIM
                                                                   : DW'(dv_q_ff[QW][c]);
      assign dres[c] = fcr.neg[c] ? (~mg + DW'(1)) : mg;
   end

   always_comb begin
      rsp_in = '0;
      if (fcr.hit) begin
         rsp_in.hit      = 1'b1;
         rsp_in.push_len = fcr.push;
         if (fcr.big) begin
            rsp_in.dir_x = dres[0];
            rsp_in.dir_y = dres[1];
            rsp_in.dir_z = dres[2];
         end else begin
            rsp_in.dir_z = LIM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/core/scnp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scnp_checker
// Port-level checks of the narrow-phase pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module scnp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input scnp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input scnp_pkg::rsp_type rsp_data
);

   localparam logic signed [scnp_pkg::DIR_W-1:0] LIM =
      scnp_pkg::DIR_W'(1) << scnp_pkg::DIR_FRAC_BITS;

   // The input side is held exactly while a finished response waits.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow a held response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held response changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |->
         rsp_data.dir_x == 0 && rsp_data.dir_y == 0 && rsp_data.dir_z == 0 &&
         rsp_data.push_len == 0)
      else $error("miss carries nonzero fields");

   a_hit_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.push_len != 0)
      else $error("hit with zero depth");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.dir_z <= LIM && rsp_data.dir_z >= -LIM &&
                    rsp_data.dir_x <= LIM && rsp_data.dir_x >= -LIM)
      else $error("direction component out of range");

   logic unused_in;
   assign unused_in = req_valid ^ (^req_data);

endmodule

bind sphere_capsule_narrow_phase scnp_checker u_scnp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
